/* hw/rtl/binary_max_heap_queue_macros.svh */
// Assertion macros for the binary max-heap queue.
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication.
`define BMHQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bmhq_pkg.sv */
// Shared types and constants for the binary max-heap queue.
package bmhq_pkg;

   localparam int DEF_CAPACITY = 64;

   localparam int PRI_W    = 16;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [PRI_W-1:0] pri;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PRI_W-1:0]    pri;
      logic [TAG_W-1:0]    tag;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

/* hw/rtl/bmhq_req_if.sv */
// Request channel: insert or pop item with valid/ready handshake.
interface bmhq_req_if
   import bmhq_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [PRI_W-1:0] priority_req;
   logic [TAG_W-1:0] tag;

   modport source (output valid, kind, priority_req, tag, input ready);
   modport sink   (input valid, kind, priority_req, tag, output ready);
endinterface

/* hw/rtl/bmhq_rsp_if.sv */
// Response channel: status, popped entry and fill count with valid/ready handshake.
interface bmhq_rsp_if
   import bmhq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PRI_W-1:0]    out_priority;
   logic [TAG_W-1:0]    out_tag;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, status, out_priority, out_tag, count, input ready);
   modport sink   (input valid, status, out_priority, out_tag, count, output ready);
endinterface

/* hw/rtl/binary_max_heap_queue.sv */
// Binary max-heap priority queue held in a one-write, two-read synchronous memory.
//
// Usage:
//   req_chan carries one item per operation: kind (insert or pop), priority_req, tag.
//   rsp_chan returns exactly one item per request: status, out_priority, out_tag, count.
//   An item moves on either channel when valid and ready are both high at a clock edge.
//   An insert puts the new entry at the end and lets it rise while its parent has a lower
//   priority; a pop reads the root and the last entry, then lets the last entry sink from
//   the root while a child has a higher priority. Full insert, empty pop and insert into
//   an empty heap answer from the idle state; a pop of the only entry answers once the
//   root is read. Each step is one memory read-modify-write per heap level: the parent
//   (insert) or both children (pop) are read while the previous move is written.
//   req_chan.ready is high whenever no operation is in flight, also while a finished
//   item waits in the output register. If rsp_chan stalls, the next result is parked in
//   a holding register and the block waits until the output register frees up.
//   Reset (synchronous, active high) empties the heap; memory contents are not cleared
//   since only entries below the fill count are ever read.
`include "binary_max_heap_queue_macros.svh"

module binary_max_heap_queue
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic            clock,
   input  logic            reset,
   bmhq_req_if.sink        req_chan,
   bmhq_rsp_if.source      rsp_chan
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = ADDR_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_POP_LOAD,
      ST_DOWN,
      ST_RESULT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   entry_type         hold_ff, hold_in;
   entry_type         pop_ff, pop_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   entry_type         heap_mem [CAPACITY];
   entry_type         rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;

   logic              req_fire;
   logic              out_free;
   logic              fin;
   logic [STATUS_W-1:0] fin_status;
   entry_type         fin_entry;
   rsp_type           fin_rsp;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   logic [ADDR_W-1:0] parent_addr;
   logic [ADDR_W-1:0] n_addr;
   logic [IDX_W-1:0]  left_idx, right_idx, best_idx, kid_l, kid_r, cnt_idx;
   logic              left_win, right_win;
   logic [PRI_W-1:0]  best_pri;
   logic [ADDR_W-1:0] best_addr;

   function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] am1;
      am1 = a - 1'b1;
      return am1 >> 1;
   endfunction

   function automatic logic [IDX_W-1:0] left_of(input logic [ADDR_W-1:0] a);
      return {1'b0, a, 1'b1};
   endfunction

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.out_priority = rsp_ff.pri;
   assign rsp_chan.out_tag      = rsp_ff.tag;
   assign rsp_chan.count        = rsp_ff.count;

   // child selection for sift-down
   assign n_addr      = count_ff[ADDR_W-1:0];
   assign parent_addr = parent_of(pos_ff);
   assign cnt_idx     = {{(IDX_W-CNT_W){1'b0}}, count_ff};
   assign left_idx    = left_of(pos_ff);
   assign right_idx   = left_idx + 1'b1;
   assign left_win    = (left_idx < cnt_idx) && (rd_a_ff.pri > hold_ff.pri);
   assign best_pri    = left_win ? rd_a_ff.pri : hold_ff.pri;
   assign right_win   = (right_idx < cnt_idx) && (rd_b_ff.pri > best_pri);
   assign best_idx    = right_win ? right_idx : left_idx;
   assign best_addr   = best_idx[ADDR_W-1:0];
   assign kid_l       = left_of(right_win || left_win ? best_addr : {ADDR_W{1'b0}});
   assign kid_r       = kid_l + 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      hold_in      = hold_ff;
      pop_in       = pop_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_a_addr    = parent_of(parent_addr);
      rd_b_addr    = kid_r[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = hold_ff;
      fin          = 1'b0;
      fin_status   = STATUS_OK;
      fin_entry    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pop_in = '0;
               if (req_chan.kind == KIND_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     fin        = 1'b1;
                     fin_status = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = '{pri: req_chan.priority_req, tag: req_chan.tag};
                     count_in = count_ff + 1'b1;
                     fin      = 1'b1;
                  end else begin
                     hold_in   = '{pri: req_chan.priority_req, tag: req_chan.tag};
                     pos_in    = n_addr;
                     rd_a_addr = parent_of(n_addr);
                     count_in  = count_ff + 1'b1;
                     state_in  = ST_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = STATUS_EMPTY;
                  end else begin
                     rd_a_addr = '0;
                     rd_b_addr = ADDR_W'(count_ff - 1'b1);
                     count_in  = count_ff - 1'b1;
                     state_in  = ST_POP_LOAD;
                  end
               end
            end
         end
         ST_UP: begin
            wr_en = 1'b1;
            if (pos_ff != '0 && rd_a_ff.pri < hold_ff.pri) begin
               wr_data   = rd_a_ff;
               pos_in    = parent_addr;
               rd_a_addr = parent_of(parent_addr);
            end else begin
               fin = 1'b1;
            end
         end
         ST_POP_LOAD: begin
            pop_in = rd_a_ff;
            if (count_ff == '0) begin
               fin       = 1'b1;
               fin_entry = rd_a_ff;
            end else begin
               // root's children
               hold_in   = rd_b_ff;
               pos_in    = '0;
               rd_a_addr = ADDR_W'(1);
               rd_b_addr = ADDR_W'(2);
               state_in  = ST_DOWN;
            end
         end
         ST_DOWN: begin
            wr_en = 1'b1;
            if (left_win || right_win) begin
               wr_data   = right_win ? rd_b_ff : rd_a_ff;
               pos_in    = best_addr;
               rd_a_addr = kid_l[ADDR_W-1:0];
               rd_b_addr = kid_r[ADDR_W-1:0];
            end else begin
               fin       = 1'b1;
               fin_entry = pop_ff;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      count_ext = {{COUNT_W{1'b0}}, count_in};
      fin_rsp   = '{status: fin_status, pri: fin_entry.pri, tag: fin_entry.tag,
                    count: count_ext[COUNT_W-1:0]};

      if (fin) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = fin_rsp;
            state_in     = ST_IDLE;
         end else begin
            res_in   = fin_rsp;
            state_in = ST_RESULT;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      hold_ff <= hold_in;
      pop_ff  <= pop_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   `BMHQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "fill count above capacity")
   `BMHQ_ASSERT_IMPL(a_write_in_heap, clock, reset, wr_en && state_ff != ST_IDLE, wr_addr < count_ff, "heap write outside held entries")
   `BMHQ_ASSERT_NEXT(a_pop_load, clock, reset, req_fire && req_chan.kind == KIND_POP && count_ff != '0, state_ff == ST_POP_LOAD, "pop on nonempty heap did not load root")

endmodule
